// ----- src/pdlm_pkg.sv -----
// ----------------------------------------------------------------------------
// pdlm_pkg
// Shared types and constants of the port DAC level mixer.
// ----------------------------------------------------------------------------
package pdlm_pkg;

  localparam int LEVEL_W   = 8;
  localparam int VOL_W     = 8;
  localparam int ADDR_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int QUAD_N    = 4;

  // product of a level and a volume, quad pair sum and full channel sum
  localparam int PROD_W    = LEVEL_W + VOL_W;
  localparam int PAIR_W    = LEVEL_W + 1;
  localparam int SUM_W     = PROD_W + 2;

  // sum * 128 / 400 == sum * 8 / 25; division by 25 through a reciprocal
  localparam int SCALED_W  = SUM_W + 3;
  localparam int RECIP_SH  = 26;
  localparam int RECIP_W   = 22;
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'((64'd1 << RECIP_SH) / 64'd25 + 64'd1);
  localparam int PROD_Q_W  = SCALED_W + RECIP_W;
  localparam int QUOT_W    = PROD_Q_W - RECIP_SH;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_A_VOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_B_VOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_VOL     = 2'd2;

  localparam logic [VOL_W-1:0] VOL_RESET = 8'd100;

  // port decode
  localparam logic [7:0] QUAD_MASK  = 8'haf;
  localparam logic [7:0] QUAD_MATCH = 8'h0f;
  localparam logic [7:0] SINGLE_B_PORT = 8'hdd;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] port_address;
    logic [7:0]        write_data;
  } in_item_t;

  typedef struct packed {
    logic                       port_claimed;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [VOL_W-1:0]     value;
  } cfg_item_t;

endpackage

// ----- src/pdlm_stream_if.sv -----
// ----------------------------------------------------------------------------
// pdlm_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface pdlm_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/port_dac_level_mixer.sv -----
// ----------------------------------------------------------------------------
// port_dac_level_mixer
// Port-mapped level DAC latches with a weighted stereo mix.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless a stalled output holds the first
// stage full. An accepted item sits in the first stage, moves on to the
// result register once that is free and leaves from there. A port write
// updates its latch at acceptance, so a following sample request sees it.
// The first stage forms the weighted sums with two 8x8 and two 9x8
// multipliers, the second scales them by 8/25 with a reciprocal multiply
// and saturates to signed 16 bits. The result register is backed by the
// first stage, so a stalled output still lets one more item in.
// Configuration writes are taken in every cycle.
module port_dac_level_mixer (
  input  logic                 clk,
  input  logic                 rst_n,
  pdlm_stream_if.sink          in_ch,
  pdlm_stream_if.source        out_ch,
  pdlm_stream_if.sink          cfg_ch
);

  logic [pdlm_pkg::VOL_W-1:0]   vol_a_r, vol_b_r, vol_q_r;
  logic [pdlm_pkg::LEVEL_W-1:0] level_a_r, level_b_r;
  logic [pdlm_pkg::LEVEL_W-1:0] quad_r [pdlm_pkg::QUAD_N];

  logic                         s1_valid_r;
  logic                         s1_sample_r;
  logic                         s1_claimed_r;
  logic [pdlm_pkg::SUM_W-1:0]   s1_left_r, s1_right_r;

  logic                         out_valid_r;
  pdlm_pkg::out_item_t          out_data_r;

  logic out_free, s1_advance, in_accept;
  pdlm_pkg::in_item_t in_item;
  pdlm_pkg::cfg_item_t cfg_item;

  assign in_item   = in_ch.data;
  assign cfg_item  = cfg_ch.data;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_a_r <= pdlm_pkg::VOL_RESET;
      vol_b_r <= pdlm_pkg::VOL_RESET;
      vol_q_r <= pdlm_pkg::VOL_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_item.index)
        pdlm_pkg::CFG_SINGLE_A_VOL: vol_a_r <= cfg_item.value;
        pdlm_pkg::CFG_SINGLE_B_VOL: vol_b_r <= cfg_item.value;
        pdlm_pkg::CFG_QUAD_VOL:     vol_q_r <= cfg_item.value;
        default: ;
      endcase
    end
  end

  // port decode
  logic [7:0] port_lo;
  logic       hit_quad, hit_a, hit_b, write_acc;
  logic [1:0] quad_sel;

  assign port_lo  = in_item.port_address[7:0];
  assign hit_quad = (port_lo & pdlm_pkg::QUAD_MASK) == pdlm_pkg::QUAD_MATCH;
  assign hit_a    = !hit_quad && !port_lo[2];
  assign hit_b    = !hit_quad && port_lo[2] && (port_lo == pdlm_pkg::SINGLE_B_PORT);
  // 0x0f, 0x1f, 0x4f, 0x5f map to latches 0..3
  assign quad_sel = {port_lo[6], port_lo[4]};
  assign write_acc = in_accept && (in_item.operation == pdlm_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_a_r <= '0;
      level_b_r <= '0;
      for (int i = 0; i < pdlm_pkg::QUAD_N; i++) begin
        quad_r[i] <= '0;
      end
    end else if (write_acc) begin
      if (hit_quad) begin
        quad_r[quad_sel] <= in_item.write_data;
      end
      if (hit_a) begin
        level_a_r <= in_item.write_data;
      end
      if (hit_b) begin
        level_b_r <= in_item.write_data;
      end
    end
  end

  // stage 1: weighted sums from the current latches
  logic [pdlm_pkg::PROD_W-1:0] prod_a, prod_b;
  logic [pdlm_pkg::PAIR_W-1:0] pair_l, pair_r;
  logic [pdlm_pkg::SUM_W-1:0]  common_sum, left_sum_nxt, right_sum_nxt;

  assign prod_a     = level_a_r * vol_a_r;
  assign prod_b     = level_b_r * vol_b_r;
  assign pair_l     = pdlm_pkg::PAIR_W'(quad_r[0]) + pdlm_pkg::PAIR_W'(quad_r[1]);
  assign pair_r     = pdlm_pkg::PAIR_W'(quad_r[2]) + pdlm_pkg::PAIR_W'(quad_r[3]);
  assign common_sum = pdlm_pkg::SUM_W'(prod_a) + pdlm_pkg::SUM_W'(prod_b);
  assign left_sum_nxt  = common_sum + pdlm_pkg::SUM_W'(pair_l * vol_q_r);
  assign right_sum_nxt = common_sum + pdlm_pkg::SUM_W'(pair_r * vol_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r  <= in_item.operation == pdlm_pkg::OP_SAMPLE;
      s1_claimed_r <= (in_item.operation == pdlm_pkg::OP_WRITE) &&
                      (hit_quad || hit_a || hit_b);
      s1_left_r    <= left_sum_nxt;
      s1_right_r   <= right_sum_nxt;
    end
  end

  // stage 2: floor(sum * 8 / 25) - 32768, saturated
  function automatic logic [pdlm_pkg::SAMPLE_W-1:0] mix_scale(
    input logic [pdlm_pkg::SUM_W-1:0] sum
  );
    logic [pdlm_pkg::SCALED_W-1:0] scaled;
    logic [pdlm_pkg::PROD_Q_W-1:0] prod;
    logic [pdlm_pkg::QUOT_W-1:0]   quot;
    scaled = {sum, 3'b000};
    prod   = pdlm_pkg::PROD_Q_W'(scaled) * pdlm_pkg::PROD_Q_W'(pdlm_pkg::RECIP_25);
    quot   = prod[pdlm_pkg::PROD_Q_W-1:pdlm_pkg::RECIP_SH];
    if (quot[pdlm_pkg::QUOT_W-1:pdlm_pkg::SAMPLE_W] != '0) begin
      mix_scale = {1'b0, {(pdlm_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      // subtracting 32768 flips the top bit
      mix_scale = {~quot[pdlm_pkg::SAMPLE_W-1], quot[pdlm_pkg::SAMPLE_W-2:0]};
    end
  endfunction

  pdlm_pkg::out_item_t out_data_nxt;

  always_comb begin
    out_data_nxt.port_claimed = s1_claimed_r;
    out_data_nxt.left_sample  = '0;
    out_data_nxt.right_sample = '0;
    if (s1_sample_r) begin
      out_data_nxt.left_sample  = mix_scale(s1_left_r);
      out_data_nxt.right_sample = mix_scale(s1_right_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- src/pdlm_checker.sv -----
// ----------------------------------------------------------------------------
// pdlm_checker
// Port-level checks of the port DAC level mixer, bound to the top level.
// ----------------------------------------------------------------------------
module pdlm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_port_claimed,
  input logic signed [pdlm_pkg::SAMPLE_W-1:0] out_left_sample,
  input logic signed [pdlm_pkg::SAMPLE_W-1:0] out_right_sample
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_port_claimed) &&
    $stable(out_left_sample) && $stable(out_right_sample))
    else $error("stalled result item changed");

  // a claimed write result carries no sample
  a_claim_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_port_claimed |-> out_left_sample == '0 && out_right_sample == '0)
    else $error("claimed write item carries sample data");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output only fills from an item that went in on the input channel
  a_fill_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item without a matching input item");

endmodule

bind port_dac_level_mixer pdlm_checker u_pdlm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_port_claimed (out_ch.data.port_claimed),
  .out_left_sample  (out_ch.data.left_sample),
  .out_right_sample (out_ch.data.right_sample)
);

// ----- verif/port_dac_level_mixer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_dac_level_mixer_tb
// Self-checking bench for the port DAC level mixer. A short table of port
// writes, sample requests and volume changes runs first, then random traffic
// over several volume settings. Every item accepted on the input channel is
// run through a local model of the latches and the mix, and each result item
// is compared field by field with the oldest expected one. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module port_dac_level_mixer_tb;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // cfg rows carry the register index in addr and the value in data
  typedef struct packed {
    row_kind_t kind;
    logic      op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        typed;
    pdlm_pkg::out_item_t res;
  } dir_row_t;

  localparam logic [7:0] PORT_QUAD_L0 = 8'h0f;
  localparam logic [7:0] PORT_QUAD_L1 = 8'h1f;
  localparam logic [7:0] PORT_QUAD_R0 = 8'h4f;
  localparam logic [7:0] PORT_QUAD_R1 = 8'h5f;
  localparam logic [pdlm_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  localparam pdlm_pkg::out_item_t NO_RES    = '0;
  localparam pdlm_pkg::out_item_t CLAIMED   = '{1'b1, 16'sh0000, 16'sh0000};
  localparam pdlm_pkg::out_item_t UNCLAIMED = '{1'b0, 16'sh0000, 16'sh0000};
  localparam pdlm_pkg::out_item_t MIX_FLOOR = '{1'b0, 16'sh8000, 16'sh8000};
  localparam pdlm_pkg::out_item_t MIX_CEIL  = '{1'b0, 16'sh7fff, 16'sh7fff};

  localparam logic OP_WR = pdlm_pkg::OP_WRITE;
  localparam logic OP_SM = pdlm_pkg::OP_SAMPLE;

  localparam int N_DIR = 26;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{ROW_ITEM, OP_SM, 16'h0000, 8'h00, 1'b1, MIX_FLOOR},
    '{ROW_ITEM, OP_WR, 16'h000f, 8'hff, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'hff1f, 8'hff, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'h004f, 8'h80, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'ha55f, 8'h01, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'h0000, 8'hff, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'h12dd, 8'hff, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'h0004, 8'h55, 1'b1, UNCLAIMED},
    '{ROW_ITEM, OP_WR, 16'hffff, 8'haa, 1'b1, UNCLAIMED},
    '{ROW_ITEM, OP_WR, 16'h7f8f, 8'h33, 1'b1, UNCLAIMED},
    '{ROW_ITEM, OP_SM, 16'hffff, 8'hff, 1'b0, NO_RES},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_SINGLE_A_VOL), 8'hff, 1'b0, NO_RES},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_SINGLE_B_VOL), 8'hff, 1'b0, NO_RES},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_QUAD_VOL),     8'hff, 1'b0, NO_RES},
    '{ROW_ITEM, OP_WR, 16'h005f, 8'hff, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_WR, 16'h804f, 8'hff, 1'b1, CLAIMED},
    // all latches and weights at full scale: both channels clip
    '{ROW_ITEM, OP_SM, 16'h0000, 8'h00, 1'b1, MIX_CEIL},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_SINGLE_A_VOL), 8'h00, 1'b0, NO_RES},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_SINGLE_B_VOL), 8'h00, 1'b0, NO_RES},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_QUAD_VOL),     8'h00, 1'b0, NO_RES},
    '{ROW_CFG,  1'b0, 16'(CFG_NONE),                   8'hff, 1'b0, NO_RES},
    '{ROW_ITEM, OP_SM, 16'h5a5a, 8'ha5, 1'b1, MIX_FLOOR},
    '{ROW_CFG,  1'b0, 16'(pdlm_pkg::CFG_QUAD_VOL),     8'h01, 1'b0, NO_RES},
    '{ROW_ITEM, OP_WR, 16'h00fb, 8'h00, 1'b1, CLAIMED},
    '{ROW_ITEM, OP_SM, 16'h0000, 8'h00, 1'b0, NO_RES},
    '{ROW_ITEM, OP_WR, 16'h80dd, 8'h00, 1'b1, CLAIMED}
  };

  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 130;

  logic clk = 1'b0;
  logic rst_n;

  pdlm_stream_if #(.data_t(pdlm_pkg::in_item_t))  in_if ();
  pdlm_stream_if #(.data_t(pdlm_pkg::out_item_t)) out_if ();
  pdlm_stream_if #(.data_t(pdlm_pkg::cfg_item_t)) cfg_if ();

  port_dac_level_mixer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the latches and weights
  logic [7:0] lat_single_a;
  logic [7:0] lat_single_b;
  logic [7:0] lat_quad [pdlm_pkg::QUAD_N];
  logic [7:0] wt_single_a;
  logic [7:0] wt_single_b;
  logic [7:0] wt_quad;

  pdlm_pkg::out_item_t expected_mix_q [$];
  int        mismatch_count = 0;
  int        send_calm = 0;

  function automatic logic signed [15:0] scale_channel(int sum);
    int v;
    v = (sum * 128) / 400 - 32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic pdlm_pkg::out_item_t mix_predict(pdlm_pkg::in_item_t it);
    pdlm_pkg::out_item_t r;
    logic [7:0] lo;
    int         common;
    r  = '0;
    lo = it.port_address[7:0];
    if (it.operation == pdlm_pkg::OP_WRITE) begin
      r.port_claimed = 1'b1;
      if ((lo & pdlm_pkg::QUAD_MASK) == pdlm_pkg::QUAD_MATCH) begin
        case (lo)
          PORT_QUAD_L0: lat_quad[0] = it.write_data;
          PORT_QUAD_L1: lat_quad[1] = it.write_data;
          PORT_QUAD_R0: lat_quad[2] = it.write_data;
          default:      lat_quad[3] = it.write_data;
        endcase
      end else if (!lo[2]) begin
        lat_single_a = it.write_data;
      end else if (lo == pdlm_pkg::SINGLE_B_PORT) begin
        lat_single_b = it.write_data;
      end else begin
        r.port_claimed = 1'b0;
      end
    end else begin
      common = lat_single_a * wt_single_a + lat_single_b * wt_single_b;
      r.left_sample  = scale_channel(common + wt_quad * (lat_quad[0] + lat_quad[1]));
      r.right_sample = scale_channel(common + wt_quad * (lat_quad[2] + lat_quad[3]));
    end
    return r;
  endfunction

  function automatic void cfg_apply(logic [pdlm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      pdlm_pkg::CFG_SINGLE_A_VOL: wt_single_a = val;
      pdlm_pkg::CFG_SINGLE_B_VOL: wt_single_b = val;
      pdlm_pkg::CFG_QUAD_VOL:     wt_quad = val;
      default: ;
    endcase
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic pdlm_pkg::in_item_t rand_port_item();
    pdlm_pkg::in_item_t it;
    int       r;
    it.operation    = pdlm_pkg::OP_WRITE;
    it.port_address = 16'($urandom);
    it.write_data   = rand_data();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      it.operation = pdlm_pkg::OP_SAMPLE;
    end else if (r < 50) begin
      case ($urandom_range(0, 3))
        0:       it.port_address[7:0] = PORT_QUAD_L0;
        1:       it.port_address[7:0] = PORT_QUAD_L1;
        2:       it.port_address[7:0] = PORT_QUAD_R0;
        default: it.port_address[7:0] = PORT_QUAD_R1;
      endcase
    end else if (r < 62) begin
      it.port_address[7:0] = pdlm_pkg::SINGLE_B_PORT;
    end else if (r < 80) begin
      it.port_address[2] = 1'b0;
    end
    return it;
  endfunction

  task automatic send_item(pdlm_pkg::in_item_t it, logic typed,
                           pdlm_pkg::out_item_t typed_res);
    int        gap;
    pdlm_pkg::out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    res = mix_predict(it);
    expected_mix_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_mix_q.size() != 0);
  endtask

  task automatic cfg_write(logic [pdlm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_apply(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, mostly short, a few long, with calm stretches
  initial begin
    int stall;
    int calm;
    int r;
    stall = 0;
    calm  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (calm > 0) begin
        calm--;
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          calm = $urandom_range(40, 200);
          out_if.ready <= 1'b1;
        end else if (r < 22) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 47) : $urandom_range(0, 2);
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    pdlm_pkg::out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_mix_q.size() == 0) begin
        $display("%0t: unexpected result item claimed=%0b left=%0d right=%0d", $time,
                 out_if.data.port_claimed, out_if.data.left_sample, out_if.data.right_sample);
        mismatch_count++;
      end else begin
        want = expected_mix_q.pop_front();
        if (out_if.data.port_claimed !== want.port_claimed) begin
          $display("%0t: port_claimed expected %0b got %0b", $time,
                   want.port_claimed, out_if.data.port_claimed);
          mismatch_count++;
        end
        if (out_if.data.left_sample !== want.left_sample) begin
          $display("%0t: left_sample expected %0d got %0d", $time,
                   want.left_sample, out_if.data.left_sample);
          mismatch_count++;
        end
        if (out_if.data.right_sample !== want.right_sample) begin
          $display("%0t: right_sample expected %0d got %0d", $time,
                   want.right_sample, out_if.data.right_sample);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0] vol [3];
    pdlm_pkg::in_item_t it;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    wt_single_a  = pdlm_pkg::VOL_RESET;
    wt_single_b  = pdlm_pkg::VOL_RESET;
    wt_quad      = pdlm_pkg::VOL_RESET;
    lat_single_a = '0;
    lat_single_b = '0;
    foreach (lat_quad[i]) lat_quad[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_results();
        cfg_write(DIRECTED[i].addr[pdlm_pkg::CFG_IDX_W-1:0], DIRECTED[i].data);
      end else begin
        it.operation    = DIRECTED[i].op;
        it.port_address = DIRECTED[i].addr;
        it.write_data   = DIRECTED[i].data;
        send_item(it, DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       vol = '{8'hff, 8'hff, 8'hff};
        1:       vol = '{8'h00, 8'h00, 8'h00};
        2:       vol = '{8'hff, 8'h00, 8'h80};
        3:       vol = '{8'h01, 8'hff, 8'h00};
        default: vol = '{8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      drain_results();
      cfg_write(pdlm_pkg::CFG_SINGLE_A_VOL, vol[0]);
      cfg_write(pdlm_pkg::CFG_SINGLE_B_VOL, vol[1]);
      cfg_write(pdlm_pkg::CFG_QUAD_VOL, vol[2]);
      if (p % 2 == 1) cfg_write(CFG_NONE, 8'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(rand_port_item(), 1'b0, NO_RES);
        // sender holds off until the pipeline is empty now and then
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** port_dac_level_mixer: PASSED **");
    end else begin
      $display("** port_dac_level_mixer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d result items outstanding", expected_mix_q.size());
    $display("** port_dac_level_mixer: FAILED **");
    $finish;
  end

endmodule

// ----- port_dac_level_mixer.f -----
src/pdlm_pkg.sv
src/pdlm_stream_if.sv
src/port_dac_level_mixer.sv
src/pdlm_checker.sv
verif/port_dac_level_mixer_tb.sv
